// ===== rtl/keyed_record_table_assert.svh =====
// assertion macros used by the table back end (krt_back)
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define KRT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define KRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/krt_pkg.sv =====
`default_nettype none
package krt_pkg;
  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_LOOKUP = 3'd1,
    FUNC_SETQTY = 3'd2,
    FUNC_DELETE = 3'd3,
    FUNC_RANGE  = 3'd4,
    FUNC_LIST   = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_INVALID   = 3'd5
  } status_e;

  localparam logic [13:0] KEY_MAX   = 14'd10000;
  localparam logic [23:0] PRICE_MAX = 24'd10000000;
  localparam logic [19:0] QTY_MAX   = 20'd1000000;

  // classified command passed from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic        key_bad;
    logic        qty_bad;
    logic        price_bad;
    logic        range_bad;
    logic [13:0] key;
    logic [23:0] price;
    logic [19:0] qty;
    logic [23:0] lo;
    logic [23:0] hi;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] rec_key;
    logic [23:0] rec_price;
    logic [19:0] rec_quantity;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EMIT,
    S_SHIFT,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/krt_if.sv =====
`default_nettype none
interface krt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [13:0] key;
  logic [23:0] price_cents;
  logic [19:0] quantity;
  logic [23:0] price_low;
  logic [23:0] price_high;
  modport source (output valid, func, key, price_cents, quantity, price_low, price_high,
                  input ready);
  modport sink (input valid, func, key, price_cents, quantity, price_low, price_high,
                output ready);
endinterface

interface krt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [13:0] rec_key;
  logic [23:0] rec_price;
  logic [19:0] rec_quantity;
  logic        last;
  modport source (output valid, status, rec_key, rec_price, rec_quantity, last, input ready);
  modport sink (input valid, status, rec_key, rec_price, rec_quantity, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/krt_front.sv =====
`default_nettype none
module krt_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  krt_in_if.sink          in_if,
  output krt_pkg::cmd_t   cmd_o,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i
);
  // two-entry queue of classified commands
  krt_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  krt_pkg::cmd_t c;
  logic push, pop;

  always_comb begin
    c.func      = in_if.func;
    c.key       = in_if.key;
    c.price     = in_if.price_cents;
    c.qty       = in_if.quantity;
    c.lo        = in_if.price_low;
    c.hi        = in_if.price_high;
    c.key_bad   = (in_if.key == 14'd0) || (in_if.key > krt_pkg::KEY_MAX);
    c.qty_bad   = in_if.quantity > krt_pkg::QTY_MAX;
    c.price_bad = in_if.price_cents > krt_pkg::PRICE_MAX;
    c.range_bad = (in_if.price_low > krt_pkg::PRICE_MAX) ||
                  (in_if.price_high > krt_pkg::PRICE_MAX) ||
                  (in_if.price_high < in_if.price_low);
  end

  assign in_if.ready = cnt_q != 2'd2;
  assign push = in_if.valid && in_if.ready;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end
endmodule
`default_nettype wire

// ===== rtl/krt_back.sv =====
`default_nettype none
`include "keyed_record_table_assert.svh"
module krt_back #(
  parameter int CAPACITY = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  krt_pkg::cmd_t  cmd_i,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  krt_out_if.source      out_if
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [57:0] mem [CAPACITY];  // key, price, quantity
  logic [57:0] rdat_q;

  krt_pkg::state_e st_q, st_d;
  krt_pkg::cmd_t   cmd_q;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic          hit_q, hit_d;    // any range match seen in the first pass
  logic          found_q, found_d;  // second pass of a scan
  logic [CW-1:0] lastm_q, lastm_d;  // last matching entry of a scan

  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [57:0]   wdat;

  krt_pkg::res_t res_q, res_d;
  logic          ov_q, ov_d;
  logic          emit;
  krt_pkg::res_t emit_res;

  // read data fields
  logic [13:0] r_key;
  logic [23:0] r_price;
  logic [19:0] r_qty;
  assign r_key   = rdat_q[57:44];
  assign r_price = rdat_q[43:20];
  assign r_qty   = rdat_q[19:0];

  logic out_free;
  assign out_free = !ov_q || out_if.ready;
  // a new command waits until the back end is idle and the result register is free or draining
  assign cmd_ready_o = (st_q == krt_pkg::S_IDLE) && out_free;
  logic take;
  assign take = cmd_valid_i && cmd_ready_o;

  logic [CW-1:0] idx_n;
  assign idx_n = idx_q + CW'(1);
  logic more;
  assign more = idx_n < cnt_q;
  logic rmatch;
  assign rmatch = (cmd_q.func == krt_pkg::FUNC_LIST) ||
                  (r_price >= cmd_q.lo && r_price <= cmd_q.hi);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      krt_pkg::S_IDLE: if (take) st_d = krt_pkg::S_SCAN;
      krt_pkg::S_SCAN: st_d = krt_pkg::S_READ;
      krt_pkg::S_READ: st_d = krt_pkg::S_EMIT;
      krt_pkg::S_EMIT: if (out_free || !emit) st_d = st_d_emit();
      krt_pkg::S_SHIFT: if (!more) st_d = krt_pkg::S_IDLE;
      krt_pkg::S_DONE: if (out_free) st_d = krt_pkg::S_IDLE;
      default: st_d = krt_pkg::S_IDLE;
    endcase
  end

  // decision made in the emit state once read data is here
  function automatic krt_pkg::state_e st_d_emit();
    krt_pkg::state_e s;
    s = krt_pkg::S_IDLE;
    case (cmd_q.func)
      krt_pkg::FUNC_INSERT: s = (r_key == cmd_q.key) ? krt_pkg::S_IDLE :
                                 (more ? krt_pkg::S_READ : krt_pkg::S_IDLE);
      krt_pkg::FUNC_LOOKUP, krt_pkg::FUNC_SETQTY:
        s = (r_key == cmd_q.key || !more) ? krt_pkg::S_IDLE : krt_pkg::S_READ;
      krt_pkg::FUNC_DELETE:
        s = (r_key == cmd_q.key) ? (more ? krt_pkg::S_SHIFT : krt_pkg::S_IDLE) :
            (more ? krt_pkg::S_READ : krt_pkg::S_IDLE);
      default: begin
        if (!found_q)
          s = (more || hit_q || rmatch) ? krt_pkg::S_READ : krt_pkg::S_IDLE;
        else
          s = (rmatch && idx_q == lastm_q) ? krt_pkg::S_IDLE : krt_pkg::S_READ;
      end
    endcase
    return s;
  endfunction

  // outputs and datapath
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; hit_d = hit_q; found_d = found_q; lastm_d = lastm_q;
    raddr = idx_q[AW-1:0];
    we = 1'b0; waddr = idx_q[AW-1:0]; wdat = rdat_q;
    emit = 1'b0;
    emit_res = '0;
    case (st_q)
      krt_pkg::S_IDLE: begin
        idx_d = '0; hit_d = 1'b0; found_d = 1'b0;
      end
      krt_pkg::S_SCAN: ;
      krt_pkg::S_READ: ;
      krt_pkg::S_EMIT: begin
        case (cmd_q.func)
          krt_pkg::FUNC_INSERT: begin
            if (r_key == cmd_q.key) begin
              emit = 1'b1; emit_res.status = krt_pkg::ST_DUP;
            end else if (!more) begin
              emit = 1'b1;
              emit_res.rec_key = cmd_q.key; emit_res.rec_price = cmd_q.price;
              emit_res.rec_quantity = cmd_q.qty;
              we = out_free; waddr = cnt_q[AW-1:0];
              wdat = {cmd_q.key, cmd_q.price, cmd_q.qty};
              if (out_free) cnt_d = cnt_q + CW'(1);
            end
          end
          krt_pkg::FUNC_LOOKUP, krt_pkg::FUNC_SETQTY, krt_pkg::FUNC_DELETE: begin
            if (r_key == cmd_q.key) begin
              emit = 1'b1;
              emit_res.rec_key = r_key; emit_res.rec_price = r_price;
              emit_res.rec_quantity = r_qty;
              if (cmd_q.func == krt_pkg::FUNC_SETQTY) begin
                emit_res.rec_quantity = cmd_q.qty;
                we = out_free; wdat = {r_key, r_price, cmd_q.qty};
              end
              if (cmd_q.func == krt_pkg::FUNC_DELETE && out_free) begin
                cnt_d = cnt_q - CW'(1);
                raddr = idx_n[AW-1:0];
              end
            end else if (!more) begin
              emit = 1'b1; emit_res.status = krt_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            if (!found_q) begin
              // first pass finds the last matching entry
              if (rmatch) begin
                hit_d = 1'b1; lastm_d = idx_q;
              end
              if (!more) begin
                if (!hit_q && !rmatch) begin
                  emit = 1'b1; emit_res.status = krt_pkg::ST_NOT_FOUND;
                end else begin
                  found_d = 1'b1; idx_d = '0; raddr = '0;
                end
              end
            end else if (rmatch) begin
              emit = 1'b1;
              emit_res.rec_key = r_key; emit_res.rec_price = r_price;
              emit_res.rec_quantity = r_qty;
              emit_res.last = (idx_q == lastm_q);
            end
          end
        endcase
        if (emit_res.status != krt_pkg::ST_OK ||
            cmd_q.func != krt_pkg::FUNC_RANGE && cmd_q.func != krt_pkg::FUNC_LIST)
          emit_res.last = 1'b1;
        // the hole of a delete stays in idx_q for the shift
        if ((out_free || !emit) && more &&
            !(cmd_q.func == krt_pkg::FUNC_DELETE && r_key == cmd_q.key)) begin
          idx_d = idx_n;
          raddr = idx_n[AW-1:0];
        end
      end
      krt_pkg::S_SHIFT: begin
        // idx_q is the hole, rdat_q holds entry idx_q+1
        we = 1'b1; waddr = idx_q[AW-1:0]; wdat = rdat_q;
        idx_d = idx_n;
        raddr = CW'(idx_n + CW'(1)) < CAP ? AW'(idx_n + CW'(1)) : '0;
      end
      krt_pkg::S_DONE: begin
        emit = 1'b1;
        emit_res = res_q;
      end
      default: ;
    endcase
  end

  // early status for commands that need no scan
  krt_pkg::res_t early;
  logic          early_v;
  always_comb begin
    early = '0; early.last = 1'b1; early_v = 1'b1;
    case (cmd_i.func)
      krt_pkg::FUNC_INSERT:
        if (cnt_q >= CAP) early.status = krt_pkg::ST_FULL;
        else if (cmd_i.key_bad || cmd_i.price_bad || cmd_i.qty_bad)
          early.status = krt_pkg::ST_INVALID;
        else if (cnt_q == '0) early_v = 1'b0;
        else early_v = 1'b0;
      krt_pkg::FUNC_LOOKUP, krt_pkg::FUNC_DELETE:
        if (cnt_q == '0) early.status = krt_pkg::ST_EMPTY;
        else if (cmd_i.key_bad) early.status = krt_pkg::ST_INVALID;
        else early_v = 1'b0;
      krt_pkg::FUNC_SETQTY:
        if (cnt_q == '0) early.status = krt_pkg::ST_EMPTY;
        else if (cmd_i.key_bad || cmd_i.qty_bad) early.status = krt_pkg::ST_INVALID;
        else early_v = 1'b0;
      krt_pkg::FUNC_RANGE:
        if (cnt_q == '0) early.status = krt_pkg::ST_EMPTY;
        else if (cmd_i.range_bad) early.status = krt_pkg::ST_INVALID;
        else early_v = 1'b0;
      krt_pkg::FUNC_LIST:
        if (cnt_q == '0) early.status = krt_pkg::ST_EMPTY;
        else early_v = 1'b0;
      default: early.status = krt_pkg::ST_INVALID;
    endcase
  end

  logic ins_empty;
  assign ins_empty = (cmd_i.func == krt_pkg::FUNC_INSERT) && !early_v && (cnt_q == '0);

  always_comb begin
    res_d = res_q;
    ov_d  = ov_q && !out_if.ready;
    if (emit && out_free && st_q != krt_pkg::S_DONE) begin
      res_d = emit_res; ov_d = 1'b1;
    end
    if (st_q == krt_pkg::S_DONE && out_free) ov_d = 1'b1;
  end

  assign out_if.valid        = ov_q;
  assign out_if.status       = res_q.status;
  assign out_if.rec_key      = res_q.rec_key;
  assign out_if.rec_price    = res_q.rec_price;
  assign out_if.rec_quantity = res_q.rec_quantity;
  assign out_if.last         = res_q.last;

  krt_pkg::state_e st_nx;
  always_comb begin
    st_nx = st_d;
    if (take && (early_v || ins_empty))
      st_nx = krt_pkg::S_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= krt_pkg::S_IDLE;
      cnt_q <= '0;
      idx_q <= '0;
      hit_q <= 1'b0;
      found_q <= 1'b0;
      lastm_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_nx;
      cnt_q <= (take && ins_empty) ? CW'(1) : cnt_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
      found_q <= found_d;
      lastm_q <= lastm_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      if (ins_empty) begin
        res_q <= '{status: krt_pkg::ST_OK, rec_key: cmd_i.key, rec_price: cmd_i.price,
                   rec_quantity: cmd_i.qty, last: 1'b1};
      end else begin
        res_q <= early;
      end
    end else begin
      res_q <= res_d;
    end
    if (take && ins_empty)
      mem[0] <= {cmd_i.key, cmd_i.price, cmd_i.qty};
    else if (we)
      mem[waddr] <= wdat;
    rdat_q <= mem[raddr];
  end

  `KRT_ASSERT(a_cnt_cap, cnt_q <= CAP)
  `KRT_ASSERT(a_idx_range, st_q == krt_pkg::S_IDLE || idx_q < CAP)
  `KRT_ASSERT_NEXT(a_hold, ov_q && !out_if.ready, ov_q && $stable(res_q))
endmodule
`default_nettype wire

// ===== rtl/keyed_record_table.sv =====
// channel | dir | fields
// in_if   | in  | func, key, price_cents, quantity, price_low, price_high
// out_if  | out | status, rec_key, rec_price, rec_quantity, last
// rejected or trivial items need no memory search; key searches read one entry at a time
// through the record memory, which has one read port and one write port
// range scan and list all take two passes over the entries and can stall on the output
// delete moves each later entry down by one; a scan gives up to entry_count results
// reset clears the entry count and control state only; no clearing pass over the memory
// a two-deep command queue lets the input side run while the back end stalls
`default_nettype none
module keyed_record_table #(
  parameter int CAPACITY = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  krt_in_if.sink    in_if,
  krt_out_if.source out_if
);
  krt_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  krt_front u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  krt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .out_if
  );
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] key;
    logic [23:0] price;
    logic [19:0] qty;
    logic [23:0] lo;
    logic [23:0] hi;
  } op_t;

  typedef struct {
    op_t           op;
    bit            typed;
    krt_pkg::res_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  krt_in_if  in_if ();
  krt_out_if out_if ();

  keyed_record_table #(.CAPACITY(64)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  // shadow copy of the table contents
  logic [13:0] tbl_key[64];
  logic [23:0] tbl_price[64];
  logic [19:0] tbl_qty[64];
  int          tbl_count;

  krt_pkg::res_t pending_res[$];
  int   errors;
  int   cycles;
  int   send_idle_pct;
  int   recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic krt_pkg::res_t mk_res(logic [2:0] st, int idx, bit fin);
    krt_pkg::res_t r;
    r = '0;
    r.status = st;
    if (st == krt_pkg::ST_OK) begin
      r.rec_key      = tbl_key[idx];
      r.rec_price    = tbl_price[idx];
      r.rec_quantity = tbl_qty[idx];
    end
    r.last = fin;
    return r;
  endfunction

  function automatic int find_rec(logic [13:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one operation to the shadow table and queue its results
  function automatic void predict_op(op_t op);
    int            idx;
    int            hits;
    bit            key_bad;
    krt_pkg::res_t r;
    key_bad = (op.key < 14'd1) || (op.key > krt_pkg::KEY_MAX);
    case (op.func)
      krt_pkg::FUNC_INSERT: begin
        if (tbl_count >= 64) pending_res.push_back(mk_res(krt_pkg::ST_FULL, 0, 1'b1));
        else if (key_bad || op.price > krt_pkg::PRICE_MAX || op.qty > krt_pkg::QTY_MAX)
          pending_res.push_back(mk_res(krt_pkg::ST_INVALID, 0, 1'b1));
        else if (find_rec(op.key) >= 0)
          pending_res.push_back(mk_res(krt_pkg::ST_DUP, 0, 1'b1));
        else begin
          tbl_key[tbl_count]   = op.key;
          tbl_price[tbl_count] = op.price;
          tbl_qty[tbl_count]   = op.qty;
          tbl_count++;
          pending_res.push_back(mk_res(krt_pkg::ST_OK, tbl_count - 1, 1'b1));
        end
      end
      krt_pkg::FUNC_LOOKUP, krt_pkg::FUNC_SETQTY, krt_pkg::FUNC_DELETE: begin
        if (tbl_count == 0) pending_res.push_back(mk_res(krt_pkg::ST_EMPTY, 0, 1'b1));
        else if (key_bad || (op.func == krt_pkg::FUNC_SETQTY && op.qty > krt_pkg::QTY_MAX))
          pending_res.push_back(mk_res(krt_pkg::ST_INVALID, 0, 1'b1));
        else begin
          idx = find_rec(op.key);
          if (idx < 0) pending_res.push_back(mk_res(krt_pkg::ST_NOT_FOUND, 0, 1'b1));
          else begin
            if (op.func == krt_pkg::FUNC_SETQTY) tbl_qty[idx] = op.qty;
            pending_res.push_back(mk_res(krt_pkg::ST_OK, idx, 1'b1));
            if (op.func == krt_pkg::FUNC_DELETE) begin
              for (int i = idx; i + 1 < tbl_count; i++) begin
                tbl_key[i]   = tbl_key[i+1];
                tbl_price[i] = tbl_price[i+1];
                tbl_qty[i]   = tbl_qty[i+1];
              end
              tbl_count--;
            end
          end
        end
      end
      krt_pkg::FUNC_RANGE, krt_pkg::FUNC_LIST: begin
        if (tbl_count == 0) pending_res.push_back(mk_res(krt_pkg::ST_EMPTY, 0, 1'b1));
        else if (op.func == krt_pkg::FUNC_RANGE &&
                 (op.lo > krt_pkg::PRICE_MAX || op.hi > krt_pkg::PRICE_MAX || op.hi < op.lo))
          pending_res.push_back(mk_res(krt_pkg::ST_INVALID, 0, 1'b1));
        else begin
          hits = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (op.func == krt_pkg::FUNC_LIST ||
                (tbl_price[i] >= op.lo && tbl_price[i] <= op.hi)) begin
              pending_res.push_back(mk_res(krt_pkg::ST_OK, i, 1'b0));
              hits++;
            end
          end
          if (hits == 0) pending_res.push_back(mk_res(krt_pkg::ST_NOT_FOUND, 0, 1'b1));
          else begin
            r = pending_res.pop_back();
            r.last = 1'b1;
            pending_res.push_back(r);
          end
        end
      end
      default: pending_res.push_back(mk_res(krt_pkg::ST_INVALID, 0, 1'b1));
    endcase
  endfunction

  // drive one transfer into the block
  task automatic send_op(op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= op.func;
    in_if.key         <= op.key;
    in_if.price_cents <= op.price;
    in_if.quantity    <= op.qty;
    in_if.price_low   <= op.lo;
    in_if.price_high  <= op.hi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_op(op);
  endtask

  function automatic op_t mk_op(logic [2:0] f, logic [13:0] k, logic [23:0] p,
                                logic [19:0] q, logic [23:0] l, logic [23:0] h);
    op_t op;
    op.func = f; op.key = k; op.price = p; op.qty = q; op.lo = l; op.hi = h;
    return op;
  endfunction

  function automatic krt_pkg::res_t st_res(logic [2:0] st);
    krt_pkg::res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // random operation, mostly legal keys from a small pool so hits are common
  function automatic op_t rand_op();
    op_t op;
    int  sel;
    op = '0;
    sel = $urandom_range(99);
    if (sel < 35) op.func = krt_pkg::FUNC_INSERT;
    else if (sel < 50) op.func = krt_pkg::FUNC_LOOKUP;
    else if (sel < 62) op.func = krt_pkg::FUNC_SETQTY;
    else if (sel < 80) op.func = krt_pkg::FUNC_DELETE;
    else if (sel < 90) op.func = krt_pkg::FUNC_RANGE;
    else if (sel < 96) op.func = krt_pkg::FUNC_LIST;
    else op.func = 3'($urandom_range(7));
    sel = $urandom_range(99);
    if (sel < 8) op.key = 14'($urandom);
    else if (sel < 25) op.key = 14'($urandom_range(10000, 1));
    else if (sel < 45 && tbl_count > 0) op.key = tbl_key[$urandom_range(tbl_count - 1)];
    else op.key = 14'($urandom_range(80, 1));
    op.price = ($urandom_range(99) < 8) ? 24'($urandom) : 24'($urandom_range(10000000));
    op.qty   = ($urandom_range(99) < 8) ? 20'($urandom) : 20'($urandom_range(1000000));
    op.lo    = 24'($urandom_range(10000000));
    op.hi    = 24'($urandom_range(10000000));
    sel = $urandom_range(99);
    if (sel < 60 && op.lo > op.hi) {op.lo, op.hi} = {op.hi, op.lo};
    else if (sel < 66) op.hi = 24'($urandom);
    else if (sel < 70) op.lo = 24'($urandom);
    return op;
  endfunction

  // receiver: random stalls, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_res.size() == 0) begin
          $error("unexpected result transfer status=%0d", out_if.status);
          errors++;
        end else begin
          krt_pkg::res_t w;
          w = pending_res.pop_front();
          if (out_if.status !== w.status) begin
            $error("status exp %0d got %0d", w.status, out_if.status); errors++;
          end
          if (out_if.rec_key !== w.rec_key) begin
            $error("rec_key exp %0d got %0d", w.rec_key, out_if.rec_key); errors++;
          end
          if (out_if.rec_price !== w.rec_price) begin
            $error("rec_price exp %0d got %0d", w.rec_price, out_if.rec_price); errors++;
          end
          if (out_if.rec_quantity !== w.rec_quantity) begin
            $error("rec_quantity exp %0d got %0d", w.rec_quantity, out_if.rec_quantity);
            errors++;
          end
          if (out_if.last !== w.last) begin
            $error("last exp %0d got %0d", w.last, out_if.last); errors++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int   phase_items;
    int   wait_cycles;
    errors = 0;
    cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 86;
    tbl_count = 0;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.key = '0;
    in_if.price_cents = '0;
    in_if.quantity = '0;
    in_if.price_low = '0;
    in_if.price_high = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: empty-table cases, extremes, every operation
    rw.typed = 1'b1; rw.want = st_res(krt_pkg::ST_EMPTY);
    rw.op = mk_op(krt_pkg::FUNC_LOOKUP, 14'd5, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_SETQTY, 14'd5, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_DELETE, 14'd5, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_RANGE, '0, '0, '0, '0, 24'hFFFFFF); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_LIST, '0, '0, '0, '0, '0); rows.push_back(rw);
    rw.want = st_res(krt_pkg::ST_INVALID);
    rw.op = mk_op(3'd6, 14'h3FFF, 24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    rows.push_back(rw);
    rw.op = mk_op(3'd7, '0, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd0, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd10001, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd1, 24'd10000001, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd1, '0, 20'd1000001, '0, '0); rows.push_back(rw);
    rw.typed = 1'b0;
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd1, 24'd0, 20'd0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd10000, 24'd10000000, 20'd1000000, '0, '0);
    rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd77, 24'd500, 20'd9, '0, '0); rows.push_back(rw);
    rw.typed = 1'b1; rw.want = st_res(krt_pkg::ST_DUP);
    rw.op = mk_op(krt_pkg::FUNC_INSERT, 14'd77, 24'd1, 20'd1, '0, '0); rows.push_back(rw);
    rw.want = st_res(krt_pkg::ST_NOT_FOUND);
    rw.op = mk_op(krt_pkg::FUNC_LOOKUP, 14'd2, '0, '0, '0, '0); rows.push_back(rw);
    rw.want = st_res(krt_pkg::ST_INVALID);
    rw.op = mk_op(krt_pkg::FUNC_SETQTY, 14'd77, '0, 20'hFFFFF, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_RANGE, '0, '0, '0, 24'd10, 24'd9); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_RANGE, '0, '0, '0, 24'd0, 24'd10000001); rows.push_back(rw);
    rw.typed = 1'b0;
    rw.op = mk_op(krt_pkg::FUNC_LOOKUP, 14'd10000, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_SETQTY, 14'd77, '0, 20'd1000000, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_RANGE, '0, '0, '0, 24'd0, 24'd10000000); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_RANGE, '0, '0, '0, 24'd501, 24'd9999999); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_DELETE, 14'd1, '0, '0, '0, '0); rows.push_back(rw);
    rw.op = mk_op(krt_pkg::FUNC_LIST, '0, '0, '0, '0, '0); rows.push_back(rw);

    foreach (rows[i]) begin
      send_op(rows[i].op);
      if (rows[i].typed) begin
        // typed row must agree with the predictor's single status result
        if (pending_res[$] != rows[i].want) begin
          $error("status exp %0d got %0d", rows[i].want.status, pending_res[$].status);
          errors++;
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 86; recv_idle_pct = 37; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      phase_items = 130;
      for (int n = 0; n < phase_items; n++) begin
        // fill the table to capacity once in the last phase to hit table full
        if (ph == 2 && n == 20) begin
          for (int k = 9000; k <= 10000 && tbl_count < 64; k++)
            send_op(mk_op(krt_pkg::FUNC_INSERT, 14'(k),
                          24'($urandom_range(10000000)),
                          20'($urandom_range(1000000)), '0, '0));
          send_op(mk_op(krt_pkg::FUNC_INSERT, 14'd1, '0, '0, '0, '0));
          send_op(mk_op(krt_pkg::FUNC_LIST, '0, '0, '0, '0, '0));
          send_op(mk_op(krt_pkg::FUNC_DELETE, tbl_key[63], '0, '0, '0, '0));
          send_op(mk_op(krt_pkg::FUNC_DELETE, tbl_key[0], '0, '0, '0, '0));
        end
        send_op(rand_op());
      end
    end
    in_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
